// ----- rtl/double_ended_queue_macros.svh -----
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define DEQ_ASSERT_IMPL(label, clk, rst, antecedent, consequent, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (antecedent) |-> (consequent)) else $error(msg);
`define DEQ_ASSERT_NEXT(label, clk, rst, antecedent, consequent, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (antecedent) |=> (consequent)) else $error(msg);
`else
`define DEQ_ASSERT_IMPL(label, clk, rst, antecedent, consequent, msg)
`define DEQ_ASSERT_NEXT(label, clk, rst, antecedent, consequent, msg)
`endif

`endif

// ----- rtl/deq_pkg.sv -----
// Shared types, constants and index helpers for the double-ended queue.
package deq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = 7;
  localparam int WORD_W = 64;

  localparam logic [WORD_W-1:0] MOST_NEGATIVE = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } deq_cmd_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

// ----- rtl/deq_ctrl.sv -----
// Controller state machine for the double-ended queue.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output deq_pkg::deq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: state_next = S_RESP;
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_RESP);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.exec = (state == S_EXEC);

endmodule

// ----- rtl/deq_dpath.sv -----
// Datapath: slot memory, end indices, entry count and result registers.
module deq_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  deq_pkg::deq_cmd_t               cmd,
  input  logic [1:0]                      op,
  input  logic signed [deq_pkg::WORD_W-1:0] data,
  output logic signed [deq_pkg::WORD_W-1:0] value,
  output logic [1:0]                      status,
  output logic [deq_pkg::CNT_W-1:0]       count
);

  logic [deq_pkg::WORD_W-1:0] slots [deq_pkg::DEPTH];

  deq_pkg::op_t               op_r;
  logic [deq_pkg::WORD_W-1:0] data_r;
  logic [deq_pkg::IDX_W-1:0]  front;
  logic [deq_pkg::IDX_W-1:0]  front_next;
  logic [deq_pkg::IDX_W-1:0]  back;
  logic [deq_pkg::IDX_W-1:0]  back_next;
  logic [deq_pkg::CNT_W-1:0]  cnt;
  logic [deq_pkg::CNT_W-1:0]  cnt_next;
  logic [deq_pkg::WORD_W-1:0] rd_data;
  deq_pkg::status_t           status_r;
  deq_pkg::status_t           status_next;
  logic                       pop_ok;
  logic                       pop_ok_next;

  logic                       wr_en;
  logic [deq_pkg::IDX_W-1:0]  wr_addr;
  logic [deq_pkg::IDX_W-1:0]  rd_addr;
  logic                       full;
  logic                       empty;

  assign full  = (cnt == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty = (cnt == '0);

  always_comb begin
    front_next  = front;
    back_next   = back;
    cnt_next    = cnt;
    status_next = deq_pkg::ST_OK;
    pop_ok_next = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = back;
    rd_addr     = front;
    unique case (op_r)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = back;
          back_next = deq_pkg::idx_inc(back);
          cnt_next  = cnt + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = deq_pkg::idx_dec(front);
          front_next = deq_pkg::idx_dec(front);
          cnt_next   = cnt + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          pop_ok_next = 1'b1;
          rd_addr     = deq_pkg::idx_dec(back);
          back_next   = deq_pkg::idx_dec(back);
          cnt_next    = cnt - deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          pop_ok_next = 1'b1;
          rd_addr     = front;
          front_next  = deq_pkg::idx_inc(front);
          cnt_next    = cnt - deq_pkg::CNT_W'(1);
        end
      end
      default: status_next = deq_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= deq_pkg::op_t'(op);
      data_r <= data;
    end
    if (cmd.exec) begin
      if (wr_en) begin
        slots[wr_addr] <= data_r;
      end
      rd_data  <= slots[rd_addr];
      status_r <= status_next;
      pop_ok   <= pop_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      cnt   <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      back  <= back_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    if (pop_ok) begin
      value = rd_data;
    end else if (status_r == deq_pkg::ST_EMPTY) begin
      value = deq_pkg::MOST_NEGATIVE;
    end else begin
      value = '0;
    end
  end

  assign status = status_r;
  assign count  = cnt;

endmodule

// ----- rtl/double_ended_queue.sv -----
// Top level of the double-ended queue: controller plus datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------
//   command  | start / busy       | op, data
//   result   | done (one cycle)   | value, status, count
//
// Each transfer passes through S_IDLE, S_EXEC and S_RESP: the accept edge
// latches the command, the edge leaving S_EXEC updates the indices, the count
// and the slot memory port and registers the read word, and the result shows
// with done in S_RESP. busy is high from the accept edge until done drops; a
// new item may start in the cycle after done. Synchronous reset empties the
// queue; the slot memory is not cleared. The receiver cannot stall results.
`include "double_ended_queue_macros.svh"

module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op,
  input  logic signed [deq_pkg::WORD_W-1:0] data,
  output logic                              done,
  output logic signed [deq_pkg::WORD_W-1:0] value,
  output logic [1:0]                        status,
  output logic [deq_pkg::CNT_W-1:0]         count
);

  deq_pkg::deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  deq_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .op     (op),
    .data   (data),
    .value  (value),
    .status (status),
    .count  (count)
  );

  `DEQ_ASSERT_IMPL(a_count_bound, clk, rst, done, count <= deq_pkg::CNT_W'(deq_pkg::DEPTH), "count exceeds depth")
  `DEQ_ASSERT_IMPL(a_full_count, clk, rst, done && status == deq_pkg::ST_FULL, count == deq_pkg::CNT_W'(deq_pkg::DEPTH) && value == '0, "full reject with wrong count or value")
  `DEQ_ASSERT_IMPL(a_empty_pop, clk, rst, done && status == deq_pkg::ST_EMPTY, count == '0 && value == deq_pkg::MOST_NEGATIVE, "empty pop with wrong count or value")
  `DEQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done, "accepted transfer not held busy")
  `DEQ_ASSERT_IMPL(a_done_busy, clk, rst, done, busy, "result shown while idle")

endmodule
